// ===== src/slim_pkg.sv =====
// Shared types and constants for the strided layout index map.
`timescale 1ns / 1ps
package slim_pkg;
   localparam int NumModes = 4;
   localparam int IndexWidth = 48;
   localparam int DimWidth = 16;
   localparam int OffsetWidth = 34;
   localparam int AddrWidth = 5;
   localparam int DataWidth = 32;

   typedef enum logic {
      OP_LINEAR = 1'b0,
      OP_COORD  = 1'b1
   } op_type;

   typedef logic [DimWidth-1:0] dim_type;

   // Per-item data that rides alongside the division chain.
   typedef struct packed {
      logic       bad;
      op_type     op;
      dim_type [NumModes-1:0] crd;
   } side_type;
endpackage

// ===== src/slim_req_if.sv =====
// Request channel: index or coordinates to map.
`timescale 1ns / 1ps
interface slim_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 operation;
   logic [slim_pkg::IndexWidth-1:0]      linear_index;
   logic [slim_pkg::DimWidth-1:0]        coord_0;
   logic [slim_pkg::DimWidth-1:0]        coord_1;
   logic [slim_pkg::DimWidth-1:0]        coord_2;
   logic [slim_pkg::DimWidth-1:0]        coord_3;

   modport source (output valid, operation, linear_index, coord_0, coord_1, coord_2, coord_3,
                   input ready);
   modport sink (input valid, operation, linear_index, coord_0, coord_1, coord_2, coord_3,
                 output ready);
endinterface

// ===== src/slim_rsp_if.sv =====
// Response channel: mapped offset and range flag.
`timescale 1ns / 1ps
interface slim_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [slim_pkg::OffsetWidth-1:0]     offset;
   logic                                 out_of_range;

   modport source (output valid, offset, out_of_range, input ready);
   modport sink (input valid, offset, out_of_range, output ready);
endinterface

// ===== src/slim_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with side data.
`timescale 1ns / 1ps
module slim_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic [slim_pkg::IndexWidth-1:0]     in_dividend,
   input  logic [slim_pkg::DimWidth-1:0]       divisor,
   input  slim_pkg::side_type                  in_side,
   output logic                                out_valid,
   output logic [slim_pkg::IndexWidth-1:0]     out_quot,
   output logic [slim_pkg::DimWidth-1:0]       out_rem,
   output slim_pkg::side_type                  out_side
);
   localparam int Steps = slim_pkg::IndexWidth;
   localparam int Dw = slim_pkg::DimWidth;

   logic [Steps-1:0]                          vld_ff;
   logic [Steps-1:0][slim_pkg::IndexWidth-1:0] dvd_ff;
   logic [Steps-1:0][Dw-1:0]                  rem_ff;
   slim_pkg::side_type [Steps-1:0]            side_ff;

   genvar i;
   generate
      for (i = 0; i < Steps; i++) begin : g_step
         logic [slim_pkg::IndexWidth-1:0] dvd_prev;
         logic [Dw-1:0]                   rem_prev;
         logic [Dw:0]                     trial;
         logic                            qbit;
         logic [slim_pkg::IndexWidth-1:0] dvd_in;
         logic [Dw-1:0]                   rem_in;

         if (i == 0) begin : g_first
            assign dvd_prev = in_dividend;
            assign rem_prev = '0;
         end else begin : g_rest
            assign dvd_prev = dvd_ff[i-1];
            assign rem_prev = rem_ff[i-1];
         end

         always_comb begin
            trial  = {rem_prev, dvd_prev[slim_pkg::IndexWidth-1]};
            qbit   = (trial >= {1'b0, divisor});
            rem_in = qbit ? Dw'(trial - {1'b0, divisor}) : trial[Dw-1:0];
            // quotient bits shift in as dividend bits shift out
            dvd_in = {dvd_prev[slim_pkg::IndexWidth-2:0], qbit};
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[i] <= 1'b0;
            end else if (en) begin
               vld_ff[i] <= (i == 0) ? in_valid : vld_ff[(i == 0) ? 0 : i-1];
            end
            if (en) begin
               dvd_ff[i]  <= dvd_in;
               rem_ff[i]  <= rem_in;
               side_ff[i] <= (i == 0) ? in_side : side_ff[(i == 0) ? 0 : i-1];
            end
         end
      end
   endgenerate

   assign out_valid = vld_ff[Steps-1];
   assign out_quot  = dvd_ff[Steps-1];
   assign out_rem   = rem_ff[Steps-1];
   assign out_side  = side_ff[Steps-1];
endmodule

// ===== src/strided_layout_index_map_top.sv =====
// Top level of the strided layout index map: register port, pipeline, output register.
`timescale 1ns / 1ps
// Pipeline from request transfer to response valid: 3 bound stages, three 48-stage dividers,
// one multiply stage, one sum/output register.
// Throughput: one item per cycle; the whole pipeline holds while the output stalls.
// Reset: synchronous, clears all valid bits and loads extents 1, stride_0 1, others 0.
module strided_layout_index_map_top #(
   parameter int MODE_COUNT = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   slim_req_if.sink                             req,
   slim_rsp_if.source                           rsp,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [slim_pkg::AddrWidth-1:0]       paddr,
   input  logic [slim_pkg::DataWidth-1:0]       pwdata,
   output logic [slim_pkg::DataWidth-1:0]       prdata,
   output logic                                 pready
);
   localparam int Nm = slim_pkg::NumModes;
   localparam int Dw = slim_pkg::DimWidth;
   localparam int Iw = slim_pkg::IndexWidth;

   slim_pkg::dim_type [Nm-1:0] ext_ff, str_ff, eff_ext, eff_str;
   logic [2:0] reg_idx;
   logic adv;

   // ---------------- register port ----------------
   assign pready  = 1'b1;
   assign reg_idx = paddr[slim_pkg::AddrWidth-1:2];
   assign prdata  = {{(slim_pkg::DataWidth-Dw){1'b0}},
                     reg_idx[2] ? str_ff[reg_idx[1:0]] : ext_ff[reg_idx[1:0]]};

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_ff <= {Nm{Dw'(1)}};
         str_ff <= {{(Nm-1){Dw'(0)}}, Dw'(1)};
      end else if (psel && penable && pwrite) begin
         if (reg_idx[2]) begin
            str_ff[reg_idx[1:0]] <= pwdata[Dw-1:0];
         end else begin
            ext_ff[reg_idx[1:0]] <= pwdata[Dw-1:0];
         end
      end
   end

   always_comb begin
      for (int m = 0; m < Nm; m++) begin
         eff_ext[m] = (m < MODE_COUNT) ? ext_ff[m] : Dw'(1);
         eff_str[m] = (m < MODE_COUNT) ? str_ff[m] : Dw'(0);
      end
   end

   // ---------------- flow control ----------------
   logic rsp_valid_ff;
   assign adv       = !rsp_valid_ff || rsp.ready;
   assign req.ready = adv;

   // ---------------- stage A: partial extent products ----------------
   logic a_valid_ff;
   slim_pkg::op_type a_op_ff;
   logic [Iw-1:0] a_idx_ff;
   slim_pkg::dim_type [Nm-1:0] a_crd_ff;
   logic [2*Dw-1:0] a_p01_ff, a_p23_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req.valid;
      end
      if (adv) begin
         a_op_ff  <= slim_pkg::op_type'(req.operation);
         a_idx_ff <= req.linear_index;
         a_crd_ff <= {req.coord_3, req.coord_2, req.coord_1, req.coord_0};
         a_p01_ff <= eff_ext[0] * eff_ext[1];
         a_p23_ff <= eff_ext[2] * eff_ext[3];
      end
   end

   // ---------------- stage B: full extent product ----------------
   logic b_valid_ff;
   slim_pkg::op_type b_op_ff;
   logic [Iw-1:0] b_idx_ff;
   slim_pkg::dim_type [Nm-1:0] b_crd_ff;
   logic [4*Dw-1:0] b_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= a_valid_ff;
      end
      if (adv) begin
         b_op_ff   <= a_op_ff;
         b_idx_ff  <= a_idx_ff;
         b_crd_ff  <= a_crd_ff;
         b_prod_ff <= a_p01_ff * a_p23_ff;
      end
   end

   // ---------------- stage C: range check ----------------
   logic c_valid_ff;
   logic [Iw-1:0] c_idx_ff;
   slim_pkg::side_type c_side_ff, c_side_in;
   logic crd_bad;

   always_comb begin
      crd_bad = 1'b0;
      for (int m = 0; m < Nm; m++) begin
         if (b_crd_ff[m] >= eff_ext[m]) crd_bad = 1'b1;
      end
      c_side_in.op  = b_op_ff;
      c_side_in.crd = b_crd_ff;
      c_side_in.bad = (b_op_ff == slim_pkg::OP_COORD) ? crd_bad
                      : ({{(4*Dw-Iw){1'b0}}, b_idx_ff} >= b_prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         c_valid_ff <= b_valid_ff;
      end
      if (adv) begin
         c_idx_ff  <= b_idx_ff;
         c_side_ff <= c_side_in;
      end
   end

   // ---------------- mixed-radix split ----------------
   logic d0_valid, d1_valid, d2_valid;
   logic [Iw-1:0] d0_quot, d1_quot, d2_quot;
   logic [Dw-1:0] d0_rem, d1_rem, d2_rem;
   slim_pkg::side_type d0_side, d1_side, d2_side, d1_side_in, d2_side_in, fin_side;

   slim_div u_div0 (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(c_valid_ff), .in_dividend(c_idx_ff), .divisor(eff_ext[0]),
      .in_side(c_side_ff),
      .out_valid(d0_valid), .out_quot(d0_quot), .out_rem(d0_rem), .out_side(d0_side)
   );

   always_comb begin
      d1_side_in = d0_side;
      if (d0_side.op == slim_pkg::OP_LINEAR) d1_side_in.crd[0] = d0_rem;
   end

   slim_div u_div1 (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(d0_valid), .in_dividend(d0_quot), .divisor(eff_ext[1]),
      .in_side(d1_side_in),
      .out_valid(d1_valid), .out_quot(d1_quot), .out_rem(d1_rem), .out_side(d1_side)
   );

   always_comb begin
      d2_side_in = d1_side;
      if (d1_side.op == slim_pkg::OP_LINEAR) d2_side_in.crd[1] = d1_rem;
   end

   slim_div u_div2 (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(d1_valid), .in_dividend(d1_quot), .divisor(eff_ext[2]),
      .in_side(d2_side_in),
      .out_valid(d2_valid), .out_quot(d2_quot), .out_rem(d2_rem), .out_side(d2_side)
   );

   // in range, the last quotient is below extent_3 and is the slowest coordinate
   always_comb begin
      fin_side = d2_side;
      if (d2_side.op == slim_pkg::OP_LINEAR) begin
         fin_side.crd[2] = d2_rem;
         fin_side.crd[3] = d2_quot[Dw-1:0];
      end
   end

   // ---------------- stride products ----------------
   logic m_valid_ff, m_bad_ff;
   logic [Nm-1:0][2*Dw-1:0] m_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (adv) begin
         m_valid_ff <= d2_valid;
      end
      if (adv) begin
         m_bad_ff <= fin_side.bad;
         for (int m = 0; m < Nm; m++) begin
            m_prod_ff[m] <= fin_side.crd[m] * eff_str[m];
         end
      end
   end

   // ---------------- sum and output register ----------------
   logic [slim_pkg::OffsetWidth-1:0] sum_in, offset_ff;
   logic oor_ff;

   always_comb begin
      sum_in = '0;
      for (int m = 0; m < Nm; m++) begin
         sum_in = sum_in + {{(slim_pkg::OffsetWidth-2*Dw){1'b0}}, m_prod_ff[m]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= m_valid_ff;
      end
      if (adv) begin
         offset_ff <= m_bad_ff ? '0 : sum_in;
         oor_ff    <= m_bad_ff;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.offset       = offset_ff;
   assign rsp.out_of_range = oor_ff;
endmodule

// ===== sim/strided_layout_index_map_top_test.sv =====
// Self-checking testbench for the strided layout index map: predicted offsets vs. the block.
`timescale 1ns / 1ps
module strided_layout_index_map_top_test;
   localparam int PipeLatency = 149;
   localparam int IdleLimit   = 20000;
   localparam int Aw          = slim_pkg::AddrWidth;
   localparam int Dtw         = slim_pkg::DataWidth;

   typedef struct {
      slim_pkg::op_type op;
      logic [47:0]      lin;
      logic [15:0]      crd [4];
   } map_req_type;

   typedef struct {
      logic [33:0] offset;
      logic        oor;
   } map_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [Aw-1:0] paddr = '0;
   logic [Dtw-1:0] pwdata = '0;
   logic [Dtw-1:0] prdata;
   logic pready;
   logic req_taken = 1'b0;

   slim_req_if req ();
   slim_rsp_if rsp ();

   strided_layout_index_map_top i_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // predictor copy of the layout registers
   logic [15:0] lay_extent [4];
   logic [15:0] lay_stride [4];

   map_req_type pending_reqs [$];
   map_rsp_type expected_offsets [$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatches = 0;
   int idle_cycles = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic map_rsp_type map_index(map_req_type r);
      map_rsp_type res;
      logic [63:0] prod, idx;
      logic [63:0] c [4];
      logic [63:0] sum;
      logic bad;
      prod = 64'd1;
      idx = 64'(r.lin);
      sum = 64'd0;
      bad = 1'b0;
      if (r.op == slim_pkg::OP_LINEAR) begin
         for (int m = 0; m < 4; m++) prod = prod * lay_extent[m];
         if (idx >= prod) begin
            bad = 1'b1;
         end else begin
            for (int m = 0; m < 4; m++) begin
               c[m] = idx % lay_extent[m];
               idx = idx / lay_extent[m];
            end
         end
      end else begin
         for (int m = 0; m < 4; m++) begin
            c[m] = 64'(r.crd[m]);
            if (r.crd[m] >= lay_extent[m]) bad = 1'b1;
         end
      end
      if (!bad) for (int m = 0; m < 4; m++) sum = sum + c[m] * lay_stride[m];
      res.offset = bad ? 34'd0 : sum[33:0];
      res.oor = bad;
      return res;
   endfunction

   // driver: one pending item at a time, changes on the falling edge
   initial begin
      req.valid = 1'b0;
      req.operation = 1'b0;
      req.linear_index = '0;
      req.coord_0 = '0;
      req.coord_1 = '0;
      req.coord_2 = '0;
      req.coord_3 = '0;
      rsp.ready = 1'b0;
   end

   always @(negedge clock) begin
      if (!reset) begin
         // req_taken tells whether the last rising edge moved a transfer
         if (!req.valid || req_taken) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               map_req_type r;
               r = pending_reqs.pop_front();
               req.operation <= r.op;
               req.linear_index <= r.lin;
               req.coord_0 <= r.crd[0];
               req.coord_1 <= r.crd[1];
               req.coord_2 <= r.crd[2];
               req.coord_3 <= r.crd[3];
               req.valid <= 1'b1;
               expected_offsets.insert(expected_offsets.size(), map_index(r));
            end else begin
               req.valid <= 1'b0;
            end
         end
         rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         req_taken <= req.valid && req.ready;
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp.valid && rsp.ready) begin
            if (expected_offsets.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response offset=%h", rsp.offset);
            end else begin
               map_rsp_type e;
               e = expected_offsets.pop_front();
               if (e.offset !== rsp.offset || e.oor !== rsp.out_of_range) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected offset=%h oor=%b, got offset=%h oor=%b",
                              e.offset, e.oor, rsp.offset, rsp.out_of_range);
               end
            end
         end
         if (idle_cycles >= IdleLimit) begin
            $display("strided_layout_index_map_top_test: FAIL");
            $finish;
         end
      end
   end

   task automatic csr_write(int idx, logic [15:0] val);
      @(negedge clock);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= Aw'(4 * idx); pwdata <= {16'h0, val};
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (idx < 4) lay_extent[idx] = val;
      else lay_stride[idx - 4] = val;
   endtask

   task automatic drain();
      // queue first empties, then in-flight items must come back
      wait (pending_reqs.size() == 0 && !req.valid);
      wait (expected_offsets.size() == 0);
      repeat (PipeLatency + 10) @(posedge clock);
   endtask

   task automatic set_layout(logic [15:0] e0, e1, e2, e3, s0, s1, s2, s3);
      csr_write(0, e0); csr_write(1, e1); csr_write(2, e2); csr_write(3, e3);
      csr_write(4, s0); csr_write(5, s1); csr_write(6, s2); csr_write(7, s3);
   endtask

   function automatic logic [15:0] rand_extent();
      case ($urandom_range(7))
         0: return 16'd0;
         1: return 16'd1;
         2: return 16'hFFFF;
         3: return 16'($urandom);
         default: return 16'($urandom_range(1, 40));
      endcase
   endfunction

   function automatic logic [15:0] rand_stride();
      case ($urandom_range(4))
         0: return 16'd0;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [63:0] extent_product();
      logic [63:0] p;
      p = 64'd1;
      for (int m = 0; m < 4; m++) p = p * lay_extent[m];
      return p;
   endfunction

   task automatic queue_random(int n);
      map_req_type r;
      logic [63:0] p;
      p = extent_product();
      for (int i = 0; i < n; i++) begin
         r.op = $urandom_range(1) ? slim_pkg::OP_COORD : slim_pkg::OP_LINEAR;
         if (r.op == slim_pkg::OP_LINEAR) begin
            if ($urandom_range(9) < 8 && p != 0)
               r.lin = 48'({$urandom, $urandom} % (p > 64'hFFFFFFFFFFFF ? 64'h1000000000000 : p));
            else
               r.lin = {16'($urandom), $urandom};
            for (int m = 0; m < 4; m++) r.crd[m] = 16'($urandom);
         end else begin
            r.lin = {16'($urandom), $urandom};
            for (int m = 0; m < 4; m++)
               if ($urandom_range(15) != 0 && lay_extent[m] != 0)
                  r.crd[m] = 16'($urandom_range(lay_extent[m] - 1));
               else
                  r.crd[m] = 16'($urandom);
         end
         pending_reqs.insert(pending_reqs.size(), r);
      end
   endtask

   task automatic queue_item(slim_pkg::op_type op, logic [47:0] lin,
                             logic [15:0] c0, c1, c2, c3);
      map_req_type r;
      r.op = op; r.lin = lin;
      r.crd[0] = c0; r.crd[1] = c1; r.crd[2] = c2; r.crd[3] = c3;
      pending_reqs.insert(pending_reqs.size(), r);
   endtask

   initial begin
      for (int m = 0; m < 4; m++) begin
         lay_extent[m] = 16'd1;
         lay_stride[m] = 16'd0;
      end
      lay_stride[0] = 16'd1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset layout, then extremes
      queue_item(slim_pkg::OP_LINEAR, 48'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      queue_item(slim_pkg::OP_LINEAR, 48'd1, 16'd0, 16'd0, 16'd0, 16'd0);
      queue_item(slim_pkg::OP_COORD, 48'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      queue_item(slim_pkg::OP_COORD, 48'hFFFFFFFFFFFF, 16'd0, 16'd0, 16'd1, 16'd0);
      drain();
      set_layout(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      queue_item(slim_pkg::OP_LINEAR, 48'hFFFFFFFFFFFF, 16'd0, 16'd0, 16'd0, 16'd0);
      queue_item(slim_pkg::OP_LINEAR, 48'hFFFEFFFEFFFE, 16'd0, 16'd0, 16'd0, 16'd0);
      queue_item(slim_pkg::OP_COORD, 48'd0, 16'hFFFE, 16'hFFFE, 16'hFFFE, 16'hFFFE);
      queue_item(slim_pkg::OP_COORD, 48'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0);
      queue_item(slim_pkg::OP_COORD, 48'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF);
      queue_item(slim_pkg::OP_LINEAR, 48'd65535, 16'd0, 16'd0, 16'd0, 16'd0);
      drain();
      // zero extent in one mode
      set_layout(16'd5, 16'd0, 16'd3, 16'd2, 16'd7, 16'd9, 16'd11, 16'd13);
      queue_item(slim_pkg::OP_LINEAR, 48'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      queue_item(slim_pkg::OP_LINEAR, 48'd3, 16'd0, 16'd0, 16'd0, 16'd0);
      queue_item(slim_pkg::OP_COORD, 48'd0, 16'd1, 16'd0, 16'd1, 16'd1);
      queue_item(slim_pkg::OP_COORD, 48'd0, 16'd4, 16'd0, 16'd2, 16'd1);
      drain();
      set_layout(16'd5, 16'd4, 16'd3, 16'd2, 16'd1, 16'd5, 16'd20, 16'd60);
      queue_item(slim_pkg::OP_LINEAR, 48'd119, 16'd0, 16'd0, 16'd0, 16'd0);
      queue_item(slim_pkg::OP_LINEAR, 48'd120, 16'd0, 16'd0, 16'd0, 16'd0);
      queue_item(slim_pkg::OP_COORD, 48'd0, 16'd4, 16'd3, 16'd2, 16'd1);
      queue_item(slim_pkg::OP_COORD, 48'd0, 16'd4, 16'd4, 16'd2, 16'd1);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase / 2)
            0: begin send_idle_pct = 31; recv_idle_pct = 54; end
            1: begin send_idle_pct = 54; recv_idle_pct = 31; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         set_layout(rand_extent(), rand_extent(), rand_extent(), rand_extent(),
                    rand_stride(), rand_stride(), rand_stride(), rand_stride());
         queue_random(172);
         drain();
      end

      if (mismatches == 0) begin
         $display("strided_layout_index_map_top_test: PASS");
      end else begin
         $display("strided_layout_index_map_top_test: FAIL");
      end
      $finish;
   end
endmodule
